/* src/vfhcds_pkg.sv */
// ----------------------------------------------------------------------------
// vfhcds_pkg: shared definitions for the candidate direction search
// Field widths, register indexes, reset values, candidate kinds and the
// event queue entry type.
// ----------------------------------------------------------------------------
package vfhcds_pkg;

  localparam int MAX_SECTORS_DEF = 256;

  localparam int TARGET_W   = 8;
  localparam int ANGLE_W    = 24;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 9;
  localparam int AMIN_W     = 18;
  localparam int SANGLE_W   = 15;
  localparam int WLIMIT_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_ANGLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_LIMIT   = 2'd3;

  localparam logic [COUNT_W-1:0]         SECTOR_COUNT_RST = 9'd72;
  localparam logic signed [AMIN_W-1:0]   ANGLE_MIN_RST    = -18'sd46080;
  localparam logic [SANGLE_W-1:0]        SECTOR_ANGLE_RST = 15'd1280;
  localparam logic [WLIMIT_W-1:0]        WIDE_LIMIT_RST   = 9'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_CENTRE = 2'd0,
    KIND_RIGHT  = 2'd1,
    KIND_LEFT   = 2'd2,
    KIND_TARGET = 2'd3
  } kind_t;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = 2;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] ang0;
    logic signed [ANGLE_W-1:0] ang1;
    logic signed [ANGLE_W-1:0] ang2;
    logic                      narrow;
    logic                      with_target;
    logic                      eoh;
  } evq_entry_t;

endpackage

/* src/vfhcds_if.sv */
// ----------------------------------------------------------------------------
// vfhcds_if: valid/ready channels of the candidate direction search
// Histogram input channel, candidate output channel and register write port.
// ----------------------------------------------------------------------------
interface vfh_in_if
  import vfhcds_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                blocked;
  logic [TARGET_W-1:0] goal_sector;

  modport source (output valid, blocked, goal_sector, input ready);
  modport sink   (input valid, blocked, goal_sector, output ready);
endinterface

interface vfh_out_if
  import vfhcds_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic [KIND_W-1:0]         kind;
  logic                      last_of_opening;
  logic                      end_of_histogram;

  modport source (output valid, angle, kind, last_of_opening, end_of_histogram,
                  input ready);
  modport sink   (input valid, angle, kind, last_of_opening, end_of_histogram,
                  output ready);
endinterface

interface vfh_cfg_if
  import vfhcds_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/vfh_candidate_direction_search_top.sv */
// ----------------------------------------------------------------------------
// vfh_candidate_direction_search_top: VFH+ candidate steering directions
// Streams histogram sector bits and emits candidate angles per free opening.
// ----------------------------------------------------------------------------
// The block takes one histogram sector bit per cycle while input ready is high.
// When an opening closes, its candidates (one centre, or right edge, left edge and
// optionally target) leave one per cycle while output ready is high. Each closed
// opening passes a three-stage datapath (sector selection, multiplication, offset
// and saturation) into a four-entry event queue; input ready drops only while
// four openings are in flight and not fully delivered.
// Registers may be written only while no transaction is pending.
module vfh_candidate_direction_search_top
  import vfhcds_pkg::*;
#(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vfh_in_if.sink    in_ch,
  vfh_out_if.source out_ch,
  vfh_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(MAX_SECTORS);
  localparam int CW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
  localparam int PW = CW + SANGLE_W;
  localparam int AW = ((PW + 2) > (ANGLE_W + 1)) ? (PW + 2) : (ANGLE_W + 1);

  localparam logic [CW-1:0] MAX_C = CW'(MAX_SECTORS);
  localparam logic signed [AW-1:0] ANG_MAX = {{(AW-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [AW-1:0] ANG_MIN = {{(AW-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};

  // Configuration registers.
  logic [COUNT_W-1:0]       sector_count_r;
  logic signed [AMIN_W-1:0] angle_min_r;
  logic [SANGLE_W-1:0]      sector_angle_r;
  logic [WLIMIT_W-1:0]      wide_limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= SECTOR_COUNT_RST;
      angle_min_r    <= ANGLE_MIN_RST;
      sector_angle_r <= SECTOR_ANGLE_RST;
      wide_limit_r   <= WIDE_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SECTOR_COUNT: sector_count_r <= cfg_ch.data[COUNT_W-1:0];
        REG_ANGLE_MIN:    angle_min_r    <= $signed(cfg_ch.data[AMIN_W-1:0]);
        REG_SECTOR_ANGLE: sector_angle_r <= cfg_ch.data[SANGLE_W-1:0];
        REG_WIDE_LIMIT:   wide_limit_r   <= cfg_ch.data[WLIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [CW-1:0] sc_ext;
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;

  always_comb begin
    sc_ext = CW'(sector_count_r);
    if (sc_ext == '0) begin
      count = CW'(1);
    end else if (sc_ext > MAX_C) begin
      count = MAX_C;
    end else begin
      count = sc_ext;
    end
    count_m1 = count - CW'(1);
  end

  // Sector tracking at the input.
  logic [IW-1:0] sector_index_r, sector_index_nxt;
  logic [IW-1:0] opening_start_r, opening_start_nxt;
  logic          in_opening_r, in_opening_nxt;
  logic [2:0]    occ_r, occ_nxt;

  logic          acc;
  logic          final_sector;
  logic          ev;
  logic [IW-1:0] ev_kr;
  logic [IW-1:0] ev_kl;
  logic          ev_eoh;

  assign in_ch.ready = (occ_r != 3'(EVQ_DEPTH));
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    final_sector      = (CW'(sector_index_r) >= count_m1);
    ev                = 1'b0;
    ev_kr             = opening_start_r;
    ev_kl             = sector_index_r;
    ev_eoh            = 1'b0;
    opening_start_nxt = opening_start_r;
    in_opening_nxt    = in_opening_r;
    if (in_ch.blocked) begin
      ev             = in_opening_r && (sector_index_r > opening_start_r);
      ev_kl          = sector_index_r - IW'(1);
      in_opening_nxt = 1'b0;
    end else begin
      if (!in_opening_r) begin
        opening_start_nxt = sector_index_r;
        ev_kr             = sector_index_r;
      end
      ev             = final_sector;
      ev_eoh         = 1'b1;
      in_opening_nxt = 1'b1;
    end
    if (final_sector) begin
      sector_index_nxt = '0;
      in_opening_nxt   = 1'b0;
    end else begin
      sector_index_nxt = sector_index_r + IW'(1);
    end
  end

  // Stage 1: closed opening.
  logic                s1_valid_r;
  logic [IW-1:0]       s1_kr_r;
  logic [IW-1:0]       s1_kl_r;
  logic [TARGET_W-1:0] s1_target_r;
  logic                s1_eoh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_index_r  <= '0;
      opening_start_r <= '0;
      in_opening_r    <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      s1_valid_r <= acc && ev;
      if (acc) begin
        sector_index_r  <= sector_index_nxt;
        opening_start_r <= opening_start_nxt;
        in_opening_r    <= in_opening_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_kr_r     <= ev_kr;
    s1_kl_r     <= ev_kl;
    s1_target_r <= in_ch.goal_sector;
    s1_eoh_r    <= ev_eoh;
  end

  // Stage 2: sector selection.
  logic [CW-1:0] krc, klc, tc, half, width, crs, cr, cl, m0;
  logic          narrow, with_target;

  always_comb begin
    krc    = CW'(s1_kr_r);
    klc    = CW'(s1_kl_r);
    tc     = CW'(s1_target_r);
    half   = CW'(wide_limit_r[WLIMIT_W-1:1]);
    width  = klc - krc + CW'(1);
    narrow = (width <= CW'(wide_limit_r));
    crs    = krc + half;
    cr     = (crs > count_m1) ? count_m1 : crs;
    cl     = (klc > half) ? (klc - half) : '0;
    with_target = (tc >= cr) && (tc <= cl);
    m0     = narrow ? (krc + klc) : cr;
  end

  logic          s2_valid_r;
  logic [CW-1:0] s2_m0_r, s2_m1_r, s2_m2_r;
  logic          s2_narrow_r, s2_wt_r, s2_eoh_r;

  always_ff @(posedge clk) begin
    s2_m0_r     <= m0;
    s2_m1_r     <= cl;
    s2_m2_r     <= tc;
    s2_narrow_r <= narrow;
    s2_wt_r     <= with_target;
    s2_eoh_r    <= s1_eoh_r;
  end

  // Stage 3: products.
  logic          s3_valid_r;
  logic [PW-1:0] s3_p0_r, s3_p1_r, s3_p2_r;
  logic          s3_narrow_r, s3_wt_r, s3_eoh_r;

  always_ff @(posedge clk) begin
    s3_p0_r     <= PW'(s2_m0_r) * PW'(sector_angle_r);
    s3_p1_r     <= PW'(s2_m1_r) * PW'(sector_angle_r);
    s3_p2_r     <= PW'(s2_m2_r) * PW'(sector_angle_r);
    s3_narrow_r <= s2_narrow_r;
    s3_wt_r     <= s2_wt_r;
    s3_eoh_r    <= s2_eoh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Stage 4: offset, saturation and queue write.
  logic signed [AW-1:0]      amin_ext;
  logic signed [AW-1:0]      sum0, sum1, sum2;
  logic [PW-1:0]             p0_sel;
  logic signed [ANGLE_W-1:0] sat0, sat1, sat2;

  always_comb begin
    amin_ext = AW'(angle_min_r);
    p0_sel   = s3_narrow_r ? (s3_p0_r >> 1) : s3_p0_r;
    sum0     = amin_ext + $signed({{(AW-PW){1'b0}}, p0_sel});
    sum1     = amin_ext + $signed({{(AW-PW){1'b0}}, s3_p1_r});
    sum2     = amin_ext + $signed({{(AW-PW){1'b0}}, s3_p2_r});
    sat0 = (sum0 > ANG_MAX) ? ANG_MAX[ANGLE_W-1:0] :
           (sum0 < ANG_MIN) ? ANG_MIN[ANGLE_W-1:0] : sum0[ANGLE_W-1:0];
    sat1 = (sum1 > ANG_MAX) ? ANG_MAX[ANGLE_W-1:0] :
           (sum1 < ANG_MIN) ? ANG_MIN[ANGLE_W-1:0] : sum1[ANGLE_W-1:0];
    sat2 = (sum2 > ANG_MAX) ? ANG_MAX[ANGLE_W-1:0] :
           (sum2 < ANG_MIN) ? ANG_MIN[ANGLE_W-1:0] : sum2[ANGLE_W-1:0];
  end

  evq_entry_t        evq_r [EVQ_DEPTH];
  logic [EVQ_AW:0]   wr_ptr_r, rd_ptr_r;
  logic [1:0]        sub_r, sub_nxt;

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      evq_r[wr_ptr_r[EVQ_AW-1:0]] <= '{ang0: sat0, ang1: sat1, ang2: sat2,
                                        narrow: s3_narrow_r,
                                        with_target: s3_wt_r,
                                        eoh: s3_eoh_r};
    end
  end

  // Candidate serializer.
  evq_entry_t head;
  logic       pop;
  logic       head_last;

  always_comb begin
    head = evq_r[rd_ptr_r[EVQ_AW-1:0]];
    head_last = head.narrow || (sub_r == 2'd2) || ((sub_r == 2'd1) && !head.with_target);
    out_ch.valid = (wr_ptr_r != rd_ptr_r);
    out_ch.end_of_histogram = head.eoh;
    out_ch.last_of_opening  = head_last;
    if (head.narrow) begin
      out_ch.angle = head.ang0;
      out_ch.kind  = KIND_CENTRE;
    end else begin
      case (sub_r)
        2'd0: begin
          out_ch.angle = head.ang0;
          out_ch.kind  = KIND_RIGHT;
        end
        2'd1: begin
          out_ch.angle = head.ang1;
          out_ch.kind  = KIND_LEFT;
        end
        default: begin
          out_ch.angle = head.ang2;
          out_ch.kind  = KIND_TARGET;
        end
      endcase
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    sub_nxt = sub_r;
    if (pop) begin
      sub_nxt = head_last ? 2'd0 : (sub_r + 2'd1);
    end
    occ_nxt = occ_r + 3'((acc && ev) ? 1 : 0) - 3'((pop && head_last) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      sub_r    <= 2'd0;
      occ_r    <= 3'd0;
    end else begin
      if (s3_valid_r) begin
        wr_ptr_r <= wr_ptr_r + (EVQ_AW+1)'(1);
      end
      if (pop && head_last) begin
        rd_ptr_r <= rd_ptr_r + (EVQ_AW+1)'(1);
      end
      sub_r <= sub_nxt;
      occ_r <= occ_nxt;
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the candidate direction search
// A queue of histogram sectors feeds a bursty valid/ready driver, and a clocked
// monitor keeps its own model of the sector walk. The model predicts every
// candidate angle, kind and flag when a sector transaction is taken. Each
// candidate transaction is checked against the oldest prediction. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import vfhcds_pkg::*;

  typedef struct {
    bit          blocked;
    logic [7:0]  target;
  } sector_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    kind_t                     kind;
    bit                        last;
    bit                        eoh;
  } cand_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vfh_in_if  in_ch();
  vfh_out_if out_ch();
  vfh_cfg_if cfg_ch();

  vfh_candidate_direction_search_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  sector_t hist_q[$];
  cand_t   cand_q[$];
  int      n_fail = 0;

  logic [COUNT_W-1:0]         cur_count;
  logic signed [AMIN_W-1:0]   cur_amin;
  logic [SANGLE_W-1:0]        cur_sangle;
  logic [WLIMIT_W-1:0]        cur_wlimit;
  int unsigned                sec_idx;
  bit                         open_flag;
  int unsigned                open_start;

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] angle_of(int unsigned k);
    return clamp_angle(longint'(cur_amin) + longint'(k) * longint'(cur_sangle));
  endfunction

  function automatic void add_cand(logic signed [ANGLE_W-1:0] ang, kind_t knd, bit lst,
                                   bit eh);
    cand_t c;
    c.angle = ang;
    c.kind = knd;
    c.last = lst;
    c.eoh = eh;
    cand_q.insert(cand_q.size(), c);
  endfunction

  function automatic void close_opening(int unsigned kr, int unsigned kl, int unsigned cnt,
                                        int unsigned tgt, bit eoh);
    int unsigned width;
    int unsigned half;
    int unsigned cr;
    int unsigned cl;
    bit          with_t;
    longint      prod;
    width = kl - kr + 1;
    half = cur_wlimit / 2;
    if (width <= cur_wlimit) begin
      prod = longint'(kr + kl) * longint'(cur_sangle);
      add_cand(clamp_angle(longint'(cur_amin) + (prod >>> 1)), KIND_CENTRE, 1'b1, eoh);
      return;
    end
    cr = kr + half;
    if (cr > cnt - 1) cr = cnt - 1;
    cl = (kl > half) ? kl - half : 0;
    with_t = (tgt >= cr) && (tgt <= cl);
    add_cand(angle_of(cr), KIND_RIGHT, 1'b0, eoh);
    add_cand(angle_of(cl), KIND_LEFT, !with_t, eoh);
    if (with_t)
      add_cand(angle_of(tgt), KIND_TARGET, 1'b1, eoh);
  endfunction

  function automatic void advance_sector(bit blk, int unsigned tgt);
    int unsigned cnt;
    bit          fin;
    cnt = cur_count;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_SECTORS_DEF) cnt = MAX_SECTORS_DEF;
    fin = (sec_idx >= cnt - 1);
    if (blk) begin
      if (open_flag && sec_idx > open_start)
        close_opening(open_start, sec_idx - 1, cnt, tgt, 1'b0);
      open_flag = 1'b0;
    end else begin
      if (!open_flag) begin
        open_flag = 1'b1;
        open_start = sec_idx;
      end
      if (fin) begin
        close_opening(open_start, sec_idx, cnt, tgt, 1'b1);
        open_flag = 1'b0;
      end
    end
    if (fin) begin
      sec_idx = 0;
      open_flag = 1'b0;
    end else begin
      sec_idx++;
    end
  endfunction

  always @(posedge clk) begin
    cand_t want;
    if (!rst_n) begin
      cur_count = SECTOR_COUNT_RST;
      cur_amin = ANGLE_MIN_RST;
      cur_sangle = SECTOR_ANGLE_RST;
      cur_wlimit = WIDE_LIMIT_RST;
      sec_idx = 0;
      open_flag = 1'b0;
      open_start = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SECTOR_COUNT: cur_count = cfg_ch.data[COUNT_W-1:0];
          REG_ANGLE_MIN:    cur_amin = cfg_ch.data[AMIN_W-1:0];
          REG_SECTOR_ANGLE: cur_sangle = cfg_ch.data[SANGLE_W-1:0];
          REG_WIDE_LIMIT:   cur_wlimit = cfg_ch.data[WLIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        advance_sector(in_ch.blocked, in_ch.goal_sector);
      if (out_ch.valid && out_ch.ready) begin
        if (cand_q.size() == 0) begin
          $error("unexpected candidate transaction: angle %0d kind %0d",
                 out_ch.angle, out_ch.kind);
          n_fail++;
        end else begin
          want = cand_q.pop_front();
          if (out_ch.angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", want.angle, out_ch.angle);
            n_fail++;
          end
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
            n_fail++;
          end
          if (out_ch.last_of_opening !== want.last) begin
            $error("last_of_opening: expected %0d, actual %0d", want.last,
                   out_ch.last_of_opening);
            n_fail++;
          end
          if (out_ch.end_of_histogram !== want.eoh) begin
            $error("end_of_histogram: expected %0d, actual %0d", want.eoh,
                   out_ch.end_of_histogram);
            n_fail++;
          end
        end
      end
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.blocked <= 1'b0;
      in_ch.goal_sector <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(hist_q.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (hist_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.blocked <= hist_q[0].blocked;
          in_ch.goal_sector <= hist_q[0].target;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  int          rx_in_seen = 0;
  int          rx_hold = 0;
  int          rx_stage = 0;
  int          rx_pat_left = 0;
  int          rx_mode = 0;
  logic [31:0] rx_pat = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) rx_in_seen++;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if ((rx_stage == 0 && rx_in_seen >= 40) ||
                   (rx_stage == 1 && rx_in_seen >= 180)) begin
        rx_stage++;
        rx_hold = 120;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_pat_left == 0) begin
          rx_pat = $urandom;
          rx_mode = $urandom_range(0, 2);
          rx_pat_left = 32;
        end
        rx_pat_left--;
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= rx_pat[rx_pat_left];
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic void push_sector(bit blk, logic [7:0] tgt);
    sector_t s;
    s.blocked = blk;
    s.target = tgt;
    hist_q.insert(hist_q.size(), s);
  endfunction

  function automatic logic [7:0] pick_target(int unsigned hi);
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, hi));
  endfunction

  task automatic queue_runs(int n_items, int unsigned max_run, int unsigned tgt_hi);
    int          k;
    int unsigned len;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        push_sector(1'($urandom_range(0, 1)), pick_target(tgt_hi));
        k++;
      end else begin
        len = $urandom_range(1, max_run);
        repeat (len) begin
          push_sector(1'b0, pick_target(tgt_hi));
          k++;
        end
        len = $urandom_range(1, 3);
        repeat (len) begin
          push_sector(1'b1, pick_target(tgt_hi));
          k++;
        end
      end
    end
  endtask

  task automatic settle();
    while (hist_q.size() != 0 || cand_q.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_regs(logic [COUNT_W-1:0] cnt, logic signed [AMIN_W-1:0] amin,
                            logic [SANGLE_W-1:0] sa, logic [WLIMIT_W-1:0] wl);
    cfg_write(REG_SECTOR_COUNT, CFG_DATA_W'(cnt));
    cfg_write(REG_ANGLE_MIN, CFG_DATA_W'(amin));
    cfg_write(REG_SECTOR_ANGLE, CFG_DATA_W'(sa));
    cfg_write(REG_WIDE_LIMIT, CFG_DATA_W'(wl));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0]       cnt;
    logic signed [AMIN_W-1:0] amin;
    logic [SANGLE_W-1:0]      sa;
    logic [WLIMIT_W-1:0]      wl;
    int unsigned              cnt_eff;
    int unsigned              max_run;
    in_ch.valid = 1'b0;
    in_ch.blocked = 1'b0;
    in_ch.goal_sector = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SECTOR_COUNT;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrow opening, then a wide one whose target sits on the right edge.
    write_regs(9'd12, ANGLE_MIN_RST, SECTOR_ANGLE_RST, 9'd4);
    @(negedge clk);
    push_sector(1'b0, 8'd255);
    push_sector(1'b0, 8'd0);
    push_sector(1'b1, 8'd0);
    repeat (8) push_sector(1'b0, 8'hAA);
    push_sector(1'b1, 8'd5);
    settle();

    // Zero sector count and zero wide limit with the largest angles.
    write_regs(9'd0, 18'sh1FFFF, 15'h7FFF, 9'd0);
    @(negedge clk);
    push_sector(1'b0, 8'd0);
    push_sector(1'b0, 8'd255);
    settle();

    // An open opening caught by a lowered sector count.
    write_regs(9'd20, ANGLE_MIN_RST, SECTOR_ANGLE_RST, 9'd2);
    @(negedge clk);
    repeat (6) push_sector(1'b0, 8'h55);
    settle();
    cfg_write(REG_SECTOR_COUNT, CFG_DATA_W'(3));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    push_sector(1'b0, 8'd1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        cnt = 9'h1FF;
        amin = 18'sh1FFFF;
        sa = 15'h7FFF;
        wl = 9'($urandom_range(2, 12));
      end else if (ph == 1) begin
        cnt = 9'd256;
        amin = 18'sh20000;
        sa = '0;
        wl = 9'h1FF;
      end else begin
        cnt = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 24));
        amin = 18'($urandom);
        sa = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
        wl = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 8));
      end
      write_regs(cnt, amin, sa, wl);
      cnt_eff = (cnt == 0) ? 1 : ((cnt > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : cnt);
      max_run = 2 * wl + 3;
      if (max_run > 40) max_run = 40;
      @(negedge clk);
      queue_runs((ph == 0) ? 256 : 12, max_run, cnt_eff - 1);
      settle();
    end

    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/vfhcds_pkg.sv
src/vfhcds_if.sv
src/vfh_candidate_direction_search_top.sv
verif/tb.sv
